@@ design/xml_entity_decoder_defines.svh @@
// Assertion macros for the XML entity decoder.
// Used by the top level; needs i_clk and i_rst_n in scope.
`ifndef XML_ENTITY_DECODER_DEFINES_SVH
`define XML_ENTITY_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define XED_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define XED_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ design/xed_pkg.sv @@
// Shared types, constants and the entity match function of the XML entity decoder.
// No dependencies.
package xed_pkg;

    localparam int HeldDepth  = 5;
    localparam int CmdBytes   = 6;
    localparam int QueueDepth = 4;

    localparam logic [7:0] ChAmp   = 8'h26;  // &
    localparam logic [7:0] ChSemi  = 8'h3B;  // ;
    localparam logic [7:0] ChLt    = 8'h3C;  // <
    localparam logic [7:0] ChGt    = 8'h3E;  // >
    localparam logic [7:0] ChApos  = 8'h27;  // '
    localparam logic [7:0] ChQuot  = 8'h22;  // "

    localparam logic [2:0] CntLtGt   = 3'd3;  // & plus two letters
    localparam logic [2:0] CntAmp    = 3'd4;
    localparam logic [2:0] CntAposQt = 3'd5;

    typedef logic [HeldDepth-1:0][7:0] t_held;

    // One command: the bytes one request produces, in order.
    typedef struct packed {
        logic [CmdBytes-1:0][7:0] bytes;
        logic [2:0]               count;   // 1..6
        logic                     eot;
    } t_cmd;

    typedef struct packed {
        logic       hit;
        logic [7:0] ch;
    } t_match;

    typedef struct packed {
        logic [2:0] held_count;
        logic       skipping;
    } t_front_status;

    // Compare the held span (without its leading '&') against the five entities.
    function automatic t_match match_entity(input t_held held, input logic [2:0] cnt);
        t_match m;
        m.hit = 1'b0;
        m.ch  = ChAmp;
        case (cnt)
            CntLtGt: begin
                if (held[1] == "l" && held[2] == "t") begin
                    m.hit = 1'b1;
                    m.ch  = ChLt;
                end else if (held[1] == "g" && held[2] == "t") begin
                    m.hit = 1'b1;
                    m.ch  = ChGt;
                end
            end
            CntAmp: begin
                if (held[1] == "a" && held[2] == "m" && held[3] == "p") begin
                    m.hit = 1'b1;
                    m.ch  = ChAmp;
                end
            end
            CntAposQt: begin
                if (held[1] == "a" && held[2] == "p" && held[3] == "o" && held[4] == "s") begin
                    m.hit = 1'b1;
                    m.ch  = ChApos;
                end else if (held[1] == "q" && held[2] == "u" && held[3] == "o"
                             && held[4] == "t") begin
                    m.hit = 1'b1;
                    m.ch  = ChQuot;
                end
            end
            default: begin
                m.hit = 1'b0;
            end
        endcase
        return m;
    endfunction

endpackage

@@ design/xed_front.sv @@
// Front end: accepts text bytes, tracks the held entity span, and turns each request
// into a command of up to six output bytes. Depends on xed_pkg.
module xed_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [7:0]             i_text_byte,
    input  logic                   i_end_of_text,
    output logic                   o_push,
    output xed_pkg::t_cmd          o_cmd,
    output xed_pkg::t_front_status o_status
);

    xed_pkg::t_held  r_held;
    logic [2:0]      r_cnt;
    logic            r_skip;
    logic [2:0]      n_cnt;
    logic            n_skip;
    logic            store;
    logic            emit;
    logic            use_char;
    logic [2:0]      flush_cnt;
    xed_pkg::t_match match;

    assign match = xed_pkg::match_entity(r_held, r_cnt);

    always_comb begin
        n_cnt     = r_cnt;
        n_skip    = r_skip;
        store     = 1'b0;
        emit      = 1'b0;
        use_char  = 1'b0;
        flush_cnt = 3'd0;
        if (r_skip) begin
            emit = 1'b1;
            if (i_text_byte == xed_pkg::ChSemi) begin
                n_skip = 1'b0;
            end
        end else if (r_cnt == 3'd0) begin
            if (i_text_byte == xed_pkg::ChAmp && !i_end_of_text) begin
                store = 1'b1;
                n_cnt = 3'd1;
            end else begin
                emit = 1'b1;
            end
        end else if (i_text_byte == xed_pkg::ChSemi) begin
            emit  = 1'b1;
            n_cnt = 3'd0;
            if (match.hit) begin
                use_char = 1'b1;
            end else begin
                flush_cnt = r_cnt;
            end
        end else if (r_cnt < 3'(xed_pkg::HeldDepth)) begin
            // at end of text flush the span together with this byte
            if (i_end_of_text) begin
                emit      = 1'b1;
                flush_cnt = r_cnt;
            end else begin
                store = 1'b1;
                n_cnt = r_cnt + 3'd1;
            end
        end else begin
            // span too long: flush and pass through to its ';'
            emit      = 1'b1;
            flush_cnt = r_cnt;
            n_cnt     = 3'd0;
            n_skip    = 1'b1;
        end
        if (i_end_of_text) begin
            n_cnt  = 3'd0;
            n_skip = 1'b0;
        end
    end

    always_comb begin
        for (int i = 0; i < xed_pkg::CmdBytes; i++) begin
            if (i < xed_pkg::HeldDepth && 3'(i) < flush_cnt) begin
                o_cmd.bytes[i] = r_held[i];
            end else begin
                o_cmd.bytes[i] = i_text_byte;
            end
        end
        o_cmd.count = flush_cnt + 3'd1;
        if (use_char) begin
            o_cmd.bytes[0] = match.ch;
            o_cmd.count    = 3'd1;
        end
        o_cmd.eot = i_end_of_text;
    end

    assign o_push   = i_accept && emit;
    assign o_status = '{held_count: r_cnt, skipping: r_skip};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 3'd0;
            r_skip <= 1'b0;
        end else if (i_accept) begin
            r_cnt  <= n_cnt;
            r_skip <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && store) begin
            r_held[r_cnt] <= i_text_byte;
        end
    end

endmodule

@@ design/xed_queue.sv @@
// Command queue between the front and back ends of the XML entity decoder.
// Depends on xed_pkg.
module xed_queue #(
    parameter int DEPTH = xed_pkg::QueueDepth
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  xed_pkg::t_cmd              i_cmd,
    input  logic                       i_pop,
    output xed_pkg::t_cmd              o_head,
    output logic                       o_empty,
    output logic                       o_full,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    xed_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_empty = (r_count == CW'(0));
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_count = r_count;
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

@@ design/xed_back.sv @@
// Back end: walks the head command one byte per cycle, while the output is not stalled, into the output register.
// Depends on xed_pkg.
module xed_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  xed_pkg::t_cmd i_head,
    input  logic          i_empty,
    output logic          o_pop,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output logic [7:0]    o_out_byte,
    output logic          o_last_of_run,
    output logic          o_text_done
);

    logic [2:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_done;
    logic       load;
    logic       last;

    assign load  = !i_empty && (!r_valid || !i_out_stall);
    assign last  = (r_idx == i_head.count - 3'd1);
    assign o_pop = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last ? 3'd0 : r_idx + 3'd1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // hold the payload while stalled
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_head.bytes[r_idx];
            r_last <= last;
            r_done <= last && i_head.eot;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_out_byte    = r_byte;
    assign o_last_of_run = r_last;
    assign o_text_done   = r_done;

endmodule

@@ design/xml_entity_decoder.sv @@
// XML entity decoder: replaces &lt; &gt; &amp; &apos; &quot; in a byte stream with
// their characters and passes everything else through in order. A byte is accepted
// every cycle while the command queue (QUEUE_DEPTH entries) has room; each accepted
// byte yields zero to six output bytes, which the back end delivers at one per cycle
// while the output is not stalled, so input keeps flowing during delivery of a flushed
// span as long as the queue has room. The first result of a byte is registered in the
// command queue and then in the back end's output register before it is on the output.
// Depends on xed_pkg, xed_front, xed_queue, xed_back and the defines header.
`include "xml_entity_decoder_defines.svh"

module xml_entity_decoder #(
    parameter int QUEUE_DEPTH = xed_pkg::QueueDepth
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_text_done
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic                   accept;
    logic                   push;
    logic                   pop;
    logic                   q_empty;
    logic                   q_full;
    logic [CW-1:0]          q_count;
    xed_pkg::t_cmd          push_cmd;
    xed_pkg::t_cmd          head_cmd;
    xed_pkg::t_front_status front_status;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    xed_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_push        (push),
        .o_cmd         (push_cmd),
        .o_status      (front_status)
    );

    xed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_count (q_count)
    );

    xed_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head_cmd),
        .i_empty       (q_empty),
        .o_pop         (pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_text_done   (o_text_done)
    );

    `XED_ASSERT_NEXT(a_eot_yields_result, accept && i_end_of_text, q_count != CW'(0), "end of text produced no queued result")
    `XED_ASSERT_NOW(a_skip_holds_nothing, front_status.skipping, front_status.held_count == 3'd0, "held bytes while skipping a span")
    `XED_ASSERT_NOW(a_held_bounded, 1'b1, front_status.held_count <= 3'(xed_pkg::HeldDepth), "held count beyond span limit")
    `XED_ASSERT_NOW(a_done_is_last, o_out_valid && o_text_done, o_last_of_run, "text done on a result that is not last of its run")

endmodule

@@ test/tb_xml_entity_decoder.sv @@
// Testbench for xml_entity_decoder: directed and random byte streams with a
// self-checking decoder model. Depends on xed_pkg and the decoder RTL.
`timescale 1ns / 100ps

module tb_xml_entity_decoder;

    localparam int CycleLimit = 60000;
    localparam int DrainLimit = 4000;
    localparam int IdlePct    = 16;
    localparam int EotPct     = 3;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       done;
    } t_dec_byte;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic [7:0] i_text_byte   = 8'h00;
    logic       i_end_of_text = 1'b0;
    logic       i_out_stall   = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_last_of_run;
    logic       o_text_done;

    // Decoder model state
    logic [7:0] span_bytes [xed_pkg::HeldDepth];
    int         span_cnt  = 0;
    bit         skip_span = 1'b0;

    t_dec_byte  run_q[$];
    t_dec_byte  decoded_q[$];
    string      entity_names[5] = '{"lt", "gt", "amp", "apos", "quot"};

    bit         idle_en   = 1'b0;
    int         errors    = 0;
    int         cycle_cnt = 0;

    xml_entity_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_text_done   (o_text_done)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CycleLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= idle_en && ($urandom_range(99) < IdlePct);
    end

    function automatic void emit_byte(input logic [7:0] b);
        run_q.push_back('{ch: b, last: 1'b0, done: 1'b0});
    endfunction

    function automatic void flush_span();
        int k;
        for (k = 0; k < span_cnt; k++) emit_byte(span_bytes[k]);
        span_cnt = 0;
    endfunction

    // Match the held span body against the predefined entity names.
    function automatic bit entity_lookup(output logic [7:0] ch);
        logic [31:0] body;
        int          len;
        int          k;
        body = '0;
        ch   = xed_pkg::ChAmp;
        len  = span_cnt - 1;
        for (k = 1; k < span_cnt; k++) body = {body[23:0], span_bytes[k]};
        if      (len == 2 && body == "lt")   ch = xed_pkg::ChLt;
        else if (len == 2 && body == "gt")   ch = xed_pkg::ChGt;
        else if (len == 3 && body == "amp")  ch = xed_pkg::ChAmp;
        else if (len == 4 && body == "apos") ch = xed_pkg::ChApos;
        else if (len == 4 && body == "quot") ch = xed_pkg::ChQuot;
        else return 1'b0;
        return 1'b1;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic eot);
        logic [7:0] ch;
        run_q.delete();
        if (skip_span) begin
            emit_byte(b);
            if (b == xed_pkg::ChSemi) skip_span = 1'b0;
        end else if (span_cnt == 0) begin
            if (b == xed_pkg::ChAmp) begin
                span_bytes[0] = b;
                span_cnt      = 1;
            end else begin
                emit_byte(b);
            end
        end else if (b == xed_pkg::ChSemi) begin
            if (entity_lookup(ch)) begin
                emit_byte(ch);
                span_cnt = 0;
            end else begin
                flush_span();
                emit_byte(b);
            end
        end else if (span_cnt < xed_pkg::HeldDepth) begin
            span_bytes[span_cnt] = b;
            span_cnt++;
        end else begin
            // over-long span: pass the rest through to its ';'
            flush_span();
            emit_byte(b);
            skip_span = 1'b1;
        end
        if (eot) begin
            flush_span();
            skip_span = 1'b0;
        end
        if (run_q.size() > 0) begin
            run_q[$].last = 1'b1;
            run_q[$].done = eot;
        end
        foreach (run_q[k]) decoded_q.push_back(run_q[k]);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eot);
        if (idle_en && $urandom_range(99) < IdlePct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_text_byte   <= b;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (o_in_stall);
        decode_byte(b, eot);
    endtask

    task automatic send_text(input string s, input bit eot_last);
        int k;
        for (k = 0; k < s.len(); k++) send_byte(s[k], eot_last && (k == s.len() - 1));
    endtask

    always @(posedge i_clk) begin
        t_dec_byte exp_b;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (decoded_q.size() == 0) begin
                $error("unexpected output byte %h", o_out_byte);
                errors++;
            end else begin
                exp_b = decoded_q.pop_front();
                if (o_out_byte !== exp_b.ch) begin
                    $error("out_byte: expected %h, actual %h", exp_b.ch, o_out_byte);
                    errors++;
                end
                if (o_last_of_run !== exp_b.last) begin
                    $error("last_of_run: expected %b, actual %b", exp_b.last, o_last_of_run);
                    errors++;
                end
                if (o_text_done !== exp_b.done) begin
                    $error("text_done: expected %b, actual %b", exp_b.done, o_text_done);
                    errors++;
                end
            end
        end
    end

    task automatic test_predefined_entities();
        idle_en = 1'b1;
        send_text("&lt;&gt;&amp;&apos;&quot;", 1'b0);
    endtask

    task automatic test_malformed_spans();
        idle_en = 1'b1;
        send_text("&;", 1'b0);
        // sixth byte overflows the span; zero and all-ones bytes ride along
        send_text("&quo", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(xed_pkg::ChSemi, 1'b0);
    endtask

    task automatic test_end_of_text_flush();
        idle_en = 1'b1;
        send_text("&a", 1'b1);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255));
        while (b == xed_pkg::ChAmp || b == xed_pkg::ChSemi);
        return b;
    endfunction

    task automatic test_random_text(input int n_bytes, input bit with_idle);
        logic [7:0] span[$];
        string      name;
        int         pick;
        int         cnt;
        int         k;
        idle_en = with_idle;
        while (n_bytes > 0) begin
            span.delete();
            pick = $urandom_range(99);
            name = entity_names[$urandom_range(4)];
            if (pick < 50) begin
                // entity name, sometimes a near miss: change, drop or add one letter
                if (pick >= 35) begin
                    case ($urandom_range(2))
                        0: name[$urandom_range(name.len() - 1)] = 8'($urandom_range("z", "a"));
                        1: name = name.substr(0, name.len() - 2);
                        default: name = {name, "s"};
                    endcase
                end
                span.push_back(xed_pkg::ChAmp);
                for (k = 0; k < name.len(); k++) span.push_back(name[k]);
                span.push_back(xed_pkg::ChSemi);
            end else if (pick < 60) begin
                span.push_back(xed_pkg::ChAmp);
                cnt = $urandom_range(8, 5);
                for (k = 0; k < cnt; k++) begin
                    span.push_back(($urandom_range(9) == 0) ? xed_pkg::ChAmp
                                                            : 8'($urandom_range("z", "a")));
                end
                span.push_back(xed_pkg::ChSemi);
            end else if (pick < 67) begin
                span.push_back(xed_pkg::ChAmp);
                if ($urandom_range(1)) begin
                    span.push_back(8'($urandom_range("z", "a")));
                    span.push_back(xed_pkg::ChAmp);
                end
                span.push_back(xed_pkg::ChSemi);
            end else if (pick < 85) begin
                cnt = $urandom_range(6, 1);
                for (k = 0; k < cnt; k++) span.push_back(plain_byte());
            end else begin
                cnt = $urandom_range(4, 1);
                for (k = 0; k < cnt; k++) span.push_back(8'($urandom_range(255)));
            end
            foreach (span[j]) begin
                send_byte(span[j], $urandom_range(99) < EotPct);
                n_bytes--;
            end
        end
    endtask

    initial begin
        int wait_cnt;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_predefined_entities();
        test_malformed_spans();
        test_end_of_text_flush();
        test_random_text(240, 1'b1);
        test_random_text(90, 1'b0);
        i_in_valid <= 1'b0;
        idle_en = 1'b1;

        // drain outstanding bytes, then allow for pipeline latency
        for (wait_cnt = 0; wait_cnt < DrainLimit && decoded_q.size() != 0; wait_cnt++) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (decoded_q.size() != 0) begin
            $error("%0d expected output bytes never delivered", decoded_q.size());
            errors++;
        end

        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
